@@ rtl/mm3h_pkg.sv @@
package mm3h_pkg;

    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 5;
    localparam int LEN_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;

    localparam logic [COUNT_W-1:0] BLOCK_BYTES = 5'd16;
    localparam logic [LEN_W:0]     LEN_LIMIT   = 33'h0_7FFF_FFFF;

    localparam logic [WORD_W-1:0] MIX_K1 = 64'h87c3_7b91_1142_53d5;
    localparam logic [WORD_W-1:0] MIX_K2 = 64'h4cf5_ad43_2745_937f;
    localparam logic [WORD_W-1:0] FIN_M1 = 64'hff51_afd7_ed55_8ccd;
    localparam logic [WORD_W-1:0] FIN_M2 = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [WORD_W-1:0] ADD_A  = 64'h0000_0000_52dc_e729;
    localparam logic [WORD_W-1:0] ADD_B  = 64'h0000_0000_3849_5ab5;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ROT,
        OP_MIX_H1,
        OP_MIX_H1B,
        OP_MIX_H2,
        OP_MIX_H2B,
        OP_TAIL_XOR,
        OP_FIN_LEN,
        OP_ADD1,
        OP_ADD2,
        OP_FM_PRE,
        OP_FM_MID,
        OP_FM_POST,
        OP_EMIT
    } t_dp_op;

    // constant pairs for the two lane multipliers
    typedef enum logic [1:0] {
        MS_K1K2,
        MS_K2K1,
        MS_M1,
        MS_M2
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        logic     mul_go;
        t_mul_sel msel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_last;
        logic in_full;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

endpackage

@@ rtl/mm3h_in_if.sv @@
interface mm3h_in_if;
    logic                             valid;
    logic                             ready;
    logic [mm3h_pkg::WORD_W-1:0]      word_low;
    logic [mm3h_pkg::WORD_W-1:0]      word_high;
    logic [mm3h_pkg::COUNT_W-1:0]     valid_bytes;
    logic                             last;

    modport source (output valid, word_low, word_high, valid_bytes, last, input ready);
    modport sink   (input valid, word_low, word_high, valid_bytes, last, output ready);
endinterface

@@ rtl/mm3h_out_if.sv @@
interface mm3h_out_if;
    logic                             valid;
    logic                             ready;
    logic [mm3h_pkg::WORD_W-1:0]      hash_low;
    logic [mm3h_pkg::WORD_W-1:0]      hash_high;
    logic                             length_overflow;

    modport source (output valid, hash_low, hash_high, length_overflow, input ready);
    modport sink   (input valid, hash_low, hash_high, length_overflow, output ready);
endinterface

@@ rtl/mm3h_datapath.sv @@
module mm3h_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mm3h_pkg::t_dp_cmd                 i_cmd,
    output mm3h_pkg::t_dp_stat                o_stat,
    input  logic [mm3h_pkg::WORD_W-1:0]       i_word_low,
    input  logic [mm3h_pkg::WORD_W-1:0]       i_word_high,
    input  logic [mm3h_pkg::COUNT_W-1:0]      i_valid_bytes,
    input  logic                              i_last,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [mm3h_pkg::WORD_W-1:0]       o_hash_low,
    output logic [mm3h_pkg::WORD_W-1:0]       o_hash_high,
    output logic                              o_length_overflow,
    input  logic                              i_cfg_we,
    input  logic [mm3h_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mm3h_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int W  = mm3h_pkg::WORD_W;
    localparam int HW = W / 2;

    // gather the first n bytes of w, optionally sign-extending each byte
    function automatic logic [W-1:0] gather(input logic [W-1:0] w,
                                            input logic [3:0] n,
                                            input logic sgn);
        logic [W-1:0] k;
        logic [W-1:0] b;
        k = '0;
        for (int i = 0; i < 8; i++) begin
            b = {{(W-8){1'b0}}, w[8*i +: 8]};
            if (sgn && w[8*i+7]) begin
                b[W-1:8] = '1;
            end
            if (4'(i) < n) begin
                k = k ^ (b << (8*i));
            end
        end
        return k;
    endfunction

    function automatic logic [W-1:0] eff_seed(input logic [W-1:0] s, input logic m);
        return m ? s : {{HW{1'b0}}, s[HW-1:0]};
    endfunction

    logic [W-1:0]                  r_seed;
    logic                          r_mode;
    logic [W-1:0]                  r_h1, r_h2, r_k1, r_k2;
    logic [mm3h_pkg::LEN_W-1:0]    r_len;
    logic                          r_ovf;

    // multiplier stages: partial products, then the wrapped 64-bit sum
    logic [W-1:0]                  r_ll1, r_ll2;
    logic [HW-1:0]                 r_lh1, r_hl1, r_lh2, r_hl2;
    logic [W-1:0]                  r_prod1, r_prod2;

    logic                          r_out_valid;
    logic [W-1:0]                  r_hash_low, r_hash_high;
    logic                          r_hash_ovf;

    logic [mm3h_pkg::COUNT_W-1:0]  vb_sat, cnt;
    logic [3:0]                    n_low, n_high;
    logic                          full;
    logic [mm3h_pkg::LEN_W:0]      len_sum;
    logic [W-1:0]                  c1, c2;
    logic [W-1:0]                  n_seed;
    logic                          n_mode;

    assign vb_sat = (i_valid_bytes > mm3h_pkg::BLOCK_BYTES) ? mm3h_pkg::BLOCK_BYTES
                                                            : i_valid_bytes;
    assign cnt    = i_last ? vb_sat : mm3h_pkg::BLOCK_BYTES;
    assign full   = (cnt == mm3h_pkg::BLOCK_BYTES);
    assign n_low  = (cnt >= 5'd8) ? 4'd8 : cnt[3:0];
    assign n_high = (cnt > 5'd8) ? 4'(cnt - 5'd8) : 4'd0;
    assign len_sum = {1'b0, r_len} + {{(mm3h_pkg::LEN_W-mm3h_pkg::COUNT_W+1){1'b0}}, cnt};

    always_comb begin
        case (i_cmd.msel)
            mm3h_pkg::MS_K1K2: begin c1 = mm3h_pkg::MIX_K1; c2 = mm3h_pkg::MIX_K2; end
            mm3h_pkg::MS_K2K1: begin c1 = mm3h_pkg::MIX_K2; c2 = mm3h_pkg::MIX_K1; end
            mm3h_pkg::MS_M1:   begin c1 = mm3h_pkg::FIN_M1; c2 = mm3h_pkg::FIN_M1; end
            default:           begin c1 = mm3h_pkg::FIN_M2; c2 = mm3h_pkg::FIN_M2; end
        endcase
    end

    // stage 1 captures on request; stage 2 sums whatever stage 1 holds
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_ll1 <= r_k1[HW-1:0] * c1[HW-1:0];
            r_lh1 <= HW'(r_k1[HW-1:0] * c1[W-1:HW]);
            r_hl1 <= HW'(r_k1[W-1:HW] * c1[HW-1:0]);
            r_ll2 <= r_k2[HW-1:0] * c2[HW-1:0];
            r_lh2 <= HW'(r_k2[HW-1:0] * c2[W-1:HW]);
            r_hl2 <= HW'(r_k2[W-1:HW] * c2[HW-1:0]);
        end
        r_prod1 <= r_ll1 + {r_lh1 + r_hl1, {HW{1'b0}}};
        r_prod2 <= r_ll2 + {r_lh2 + r_hl2, {HW{1'b0}}};
    end

    always_comb begin
        n_seed = r_seed;
        n_mode = r_mode;
        if (i_cfg_idx == mm3h_pkg::CFG_SEED) begin
            n_seed = i_cfg_data;
        end else if (i_cfg_idx == mm3h_pkg::CFG_MODE) begin
            n_mode = i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_mode      <= 1'b0;
            r_h1        <= '0;
            r_h2        <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == mm3h_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                mm3h_pkg::OP_LOAD: begin
                    if (full) begin
                        r_k1 <= i_word_low;
                        r_k2 <= i_word_high;
                    end else begin
                        r_k1 <= gather(i_word_low, n_low, r_mode);
                        r_k2 <= gather(i_word_high, n_high, r_mode);
                    end
                    r_len <= len_sum[mm3h_pkg::LEN_W-1:0];
                    if (len_sum > mm3h_pkg::LEN_LIMIT) begin
                        r_ovf <= 1'b1;
                    end
                end
                mm3h_pkg::OP_ROT: begin
                    r_k1 <= mm3h_pkg::rotl64(r_prod1, 31);
                    r_k2 <= mm3h_pkg::rotl64(r_prod2, 33);
                end
                mm3h_pkg::OP_MIX_H1:  r_h1 <= mm3h_pkg::rotl64(r_h1 ^ r_prod1, 27) + r_h2;
                mm3h_pkg::OP_MIX_H1B: r_h1 <= r_h1 + (r_h1 << 2) + mm3h_pkg::ADD_A;
                mm3h_pkg::OP_MIX_H2:  r_h2 <= mm3h_pkg::rotl64(r_h2 ^ r_prod2, 31) + r_h1;
                mm3h_pkg::OP_MIX_H2B: r_h2 <= r_h2 + (r_h2 << 2) + mm3h_pkg::ADD_B;
                mm3h_pkg::OP_TAIL_XOR: begin
                    // an empty tail half gathers to zero and scrambles to zero
                    r_h1 <= r_h1 ^ r_prod1;
                    r_h2 <= r_h2 ^ r_prod2;
                end
                mm3h_pkg::OP_FIN_LEN: begin
                    r_h1 <= r_h1 ^ {{(W-mm3h_pkg::LEN_W){1'b0}}, r_len};
                    r_h2 <= r_h2 ^ {{(W-mm3h_pkg::LEN_W){1'b0}}, r_len};
                end
                mm3h_pkg::OP_ADD1: r_h1 <= r_h1 + r_h2;
                mm3h_pkg::OP_ADD2: r_h2 <= r_h2 + r_h1;
                mm3h_pkg::OP_FM_PRE: begin
                    r_k1 <= r_h1 ^ (r_h1 >> 33);
                    r_k2 <= r_h2 ^ (r_h2 >> 33);
                end
                mm3h_pkg::OP_FM_MID: begin
                    r_k1 <= r_prod1 ^ (r_prod1 >> 33);
                    r_k2 <= r_prod2 ^ (r_prod2 >> 33);
                end
                mm3h_pkg::OP_FM_POST: begin
                    r_h1 <= r_prod1 ^ (r_prod1 >> 33);
                    r_h2 <= r_prod2 ^ (r_prod2 >> 33);
                end
                mm3h_pkg::OP_EMIT: begin
                    r_hash_low  <= r_h1;
                    r_hash_high <= r_mode ? '0 : r_h2;
                    r_hash_ovf  <= r_ovf;
                    r_h1        <= eff_seed(r_seed, r_mode);
                    r_h2        <= eff_seed(r_seed, r_mode);
                    r_len       <= '0;
                    r_ovf       <= 1'b0;
                end
                default: ;
            endcase
            // config writes must come only while idle (unchecked here) and drop any partial message
            if (i_cfg_we && (i_cfg_idx == mm3h_pkg::CFG_SEED ||
                             i_cfg_idx == mm3h_pkg::CFG_MODE)) begin
                r_seed <= n_seed;
                r_mode <= n_mode;
                r_h1   <= eff_seed(n_seed, n_mode);
                r_h2   <= eff_seed(n_seed, n_mode);
                r_len  <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    assign o_stat.in_last  = i_last;
    assign o_stat.in_full  = full;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_hash_low        = r_hash_low;
    assign o_hash_high       = r_hash_high;
    assign o_length_overflow = r_hash_ovf;

endmodule

@@ rtl/mm3h_ctrl.sv @@
module mm3h_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mm3h_pkg::t_dp_stat  i_stat,
    output mm3h_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_M1_ISSUE, S_M1_SUM, S_ROT,
        S_M2_ISSUE, S_M2_SUM, S_MIX,
        S_H1B, S_H2, S_H2B,
        S_FIN_LEN, S_FIN_ADD1, S_FIN_ADD2,
        S_FM_PRE, S_F1_ISSUE, S_F1_SUM, S_FM_MID,
        S_F2_ISSUE, S_F2_SUM, S_FM_POST,
        S_FIN_ADD3, S_FIN_ADD4, S_EMIT
    } t_state;

    t_state r_state;
    logic   r_last;
    logic   r_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_body  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last  <= i_stat.in_last;
                        r_body  <= i_stat.in_full;
                        r_state <= S_M1_ISSUE;
                    end
                end
                S_M1_ISSUE: r_state <= S_M1_SUM;
                S_M1_SUM:   r_state <= S_ROT;
                S_ROT:      r_state <= S_M2_ISSUE;
                S_M2_ISSUE: r_state <= S_M2_SUM;
                S_M2_SUM:   r_state <= S_MIX;
                S_MIX:      r_state <= r_body ? S_H1B : S_FIN_LEN;
                S_H1B:      r_state <= S_H2;
                S_H2:       r_state <= S_H2B;
                S_H2B:      r_state <= r_last ? S_FIN_LEN : S_IDLE;
                S_FIN_LEN:  r_state <= S_FIN_ADD1;
                S_FIN_ADD1: r_state <= S_FIN_ADD2;
                S_FIN_ADD2: r_state <= S_FM_PRE;
                S_FM_PRE:   r_state <= S_F1_ISSUE;
                S_F1_ISSUE: r_state <= S_F1_SUM;
                S_F1_SUM:   r_state <= S_FM_MID;
                S_FM_MID:   r_state <= S_F2_ISSUE;
                S_F2_ISSUE: r_state <= S_F2_SUM;
                S_F2_SUM:   r_state <= S_FM_POST;
                S_FM_POST:  r_state <= S_FIN_ADD3;
                S_FIN_ADD3: r_state <= S_FIN_ADD4;
                S_FIN_ADD4: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.op     = mm3h_pkg::OP_NOP;
        o_cmd.mul_go = 1'b0;
        o_cmd.msel   = mm3h_pkg::MS_K1K2;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) o_cmd.op = mm3h_pkg::OP_LOAD;
            S_M1_ISSUE: o_cmd.mul_go = 1'b1;
            S_ROT:      o_cmd.op = mm3h_pkg::OP_ROT;
            S_M2_ISSUE: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = mm3h_pkg::MS_K2K1;
            end
            S_MIX:      o_cmd.op = r_body ? mm3h_pkg::OP_MIX_H1 : mm3h_pkg::OP_TAIL_XOR;
            S_H1B:      o_cmd.op = mm3h_pkg::OP_MIX_H1B;
            S_H2:       o_cmd.op = mm3h_pkg::OP_MIX_H2;
            S_H2B:      o_cmd.op = mm3h_pkg::OP_MIX_H2B;
            S_FIN_LEN:  o_cmd.op = mm3h_pkg::OP_FIN_LEN;
            S_FIN_ADD1, S_FIN_ADD3: o_cmd.op = mm3h_pkg::OP_ADD1;
            S_FIN_ADD2, S_FIN_ADD4: o_cmd.op = mm3h_pkg::OP_ADD2;
            S_FM_PRE:   o_cmd.op = mm3h_pkg::OP_FM_PRE;
            S_F1_ISSUE: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = mm3h_pkg::MS_M1;
            end
            S_FM_MID:   o_cmd.op = mm3h_pkg::OP_FM_MID;
            S_F2_ISSUE: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = mm3h_pkg::MS_M2;
            end
            S_FM_POST:  o_cmd.op = mm3h_pkg::OP_FM_POST;
            S_EMIT:     if (!i_stat.out_busy) o_cmd.op = mm3h_pkg::OP_EMIT;
            default: ;
        endcase
    end

endmodule

@@ rtl/murmur3_128_block_hasher.sv @@
// Streaming MurmurHash3 x64_128: one 16-byte block per input beat.
// Non-last beat: body round (multiply, rotate, multiply, lane mixes), then back to idle.
// Last beat: body round for a full block or tail mix for a partial one, then the
// length fold, finalizer and emit into the output register, held by any output stall.
// Rate is set by the 64-bit lane multipliers, run 2x per round.
// Sync active-low reset: seed and mode 0, lanes 0, length 0, no result pending.
module murmur3_128_block_hasher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mm3h_in_if.sink                           i_blk,
    mm3h_out_if.source                        o_hash,
    input  logic                              i_cfg_we,
    input  logic [mm3h_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mm3h_pkg::WORD_W-1:0]       i_cfg_data
);

    // controller/datapath handshake
    mm3h_pkg::t_dp_cmd  cmd;
    mm3h_pkg::t_dp_stat stat;
    logic               in_ready;

    // Controller: sequences body round, tail mix and finalizer ops one per cycle, but waits in
    // emit while the output is busy. Input beats are taken only in idle; the output register
    // decouples the result side, so a new block is taken while a hash waits.
    mm3h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_blk.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_blk.ready = in_ready;

    // Datapath: lanes, length counter, two 64x64 (mod 2^64) multipliers built
    // from 32x32 partial products, config registers and the result register.
    mm3h_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_word_low        (i_blk.word_low),
        .i_word_high       (i_blk.word_high),
        .i_valid_bytes     (i_blk.valid_bytes),
        .i_last            (i_blk.last),
        .i_out_ready       (o_hash.ready),
        .o_out_valid       (o_hash.valid),
        .o_hash_low        (o_hash.hash_low),
        .o_hash_high       (o_hash.hash_high),
        .o_length_overflow (o_hash.length_overflow),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

endmodule

@@ tb/sv/mm3h_digest_checker.sv @@
`timescale 1ns / 100ps

// Watches the block and hash channels and the register port, keeps its own
// copy of the hash state, and checks each hash beat against the oldest
// predicted digest.
module mm3h_digest_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mm3h_in_if                                  i_blk,
    mm3h_out_if                                 i_hash,
    input  logic                                i_cfg_we,
    input  logic [mm3h_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mm3h_pkg::WORD_W-1:0]         i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_open_digests
);

    localparam logic [63:0] C_K1   = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] C_K2   = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] C_F1   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] C_F2   = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [63:0] C_ADDA = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] C_ADDB = 64'h0000_0000_3849_5ab5;
    localparam logic [32:0] C_LEN_MAX = 33'h0_7fff_ffff;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        ovf;
    } t_digest;

    t_digest     digest_q[$];
    logic [63:0] seed_r;
    logic        mode_r;
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [31:0] byte_count;
    logic        len_flag;
    int          fails = 0;
    int          shown = 0;

    function automatic logic [63:0] rol(input logic [63:0] v, input int unsigned r);
        logic [127:0] d;
        d = {v, v} << r;
        return d[127:64];
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] k);
        logic [63:0] x;
        x = k ^ (k >> 33);
        x = x * C_F1;
        x = x ^ (x >> 33);
        x = x * C_F2;
        return x ^ (x >> 33);
    endfunction

    function automatic logic [63:0] mix_k1(input logic [63:0] k);
        return rol(k * C_K1, 31) * C_K2;
    endfunction

    function automatic logic [63:0] mix_k2(input logic [63:0] k);
        return rol(k * C_K2, 33) * C_K1;
    endfunction

    // lanes back to the effective seed, length and flag cleared
    function automatic void reload();
        lane_a     = mode_r ? seed_r : {32'h0, seed_r[31:0]};
        lane_b     = lane_a;
        byte_count = '0;
        len_flag   = 1'b0;
    endfunction

    function automatic void grow_length(input logic [4:0] n);
        logic [32:0] t;
        t = {1'b0, byte_count} + 33'(n);
        if (t > C_LEN_MAX) len_flag = 1'b1;
        byte_count = t[31:0];
    endfunction

    function automatic void body_mix(input logic [63:0] k1, input logic [63:0] k2);
        lane_a = lane_a ^ mix_k1(k1);
        lane_a = rol(lane_a, 27) + lane_b;
        lane_a = lane_a * 64'd5 + C_ADDA;
        lane_b = lane_b ^ mix_k2(k2);
        lane_b = rol(lane_b, 31) + lane_a;
        lane_b = lane_b * 64'd5 + C_ADDB;
    endfunction

    // first nbytes bytes of w, optionally sign-extended per byte
    function automatic logic [63:0] tail_word(input logic [63:0] w, input int nbytes,
                                              input logic sx);
        logic [63:0] k;
        logic [63:0] b;
        k = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) begin
                b = {56'h0, w[8*i +: 8]};
                if (sx && b[7]) b[63:8] = '1;
                k = k ^ (b << (8 * i));
            end
        end
        return k;
    endfunction

    function automatic void absorb(input logic [63:0] wl, input logic [63:0] wh,
                                   input logic [4:0] nb, input logic fin);
        logic [4:0]  n;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] len;
        t_digest     d;
        if (!fin) begin
            // non-final beats always count as a full block
            body_mix(wl, wh);
            grow_length(mm3h_pkg::BLOCK_BYTES);
            return;
        end
        n = (nb > mm3h_pkg::BLOCK_BYTES) ? mm3h_pkg::BLOCK_BYTES : nb;
        grow_length(n);
        if (n == mm3h_pkg::BLOCK_BYTES) begin
            body_mix(wl, wh);
        end else begin
            if (n > 5'd8) lane_b = lane_b ^ mix_k2(tail_word(wh, int'(n) - 8, mode_r));
            if (n > 5'd0) lane_a = lane_a ^ mix_k1(tail_word(wl, int'(n), mode_r));
        end
        len = {32'h0, byte_count};
        h1  = lane_a ^ len;
        h2  = lane_b ^ len;
        h1  = h1 + h2;
        h2  = h2 + h1;
        h1  = fmix(h1);
        h2  = fmix(h2);
        h1  = h1 + h2;
        d.lo = h1;
        d.hi = mode_r ? 64'h0 : h2 + h1;
        d.ovf = len_flag;
        digest_q.push_back(d);
        reload();
    endfunction

    always @(posedge i_clk) begin
        t_digest got;
        t_digest want;
        if (!i_rst_n) begin
            seed_r = '0;
            mode_r = 1'b0;
            reload();
            digest_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mm3h_pkg::CFG_SEED: begin
                        seed_r = i_cfg_data;
                        reload();
                    end
                    mm3h_pkg::CFG_MODE: begin
                        mode_r = i_cfg_data[0];
                        reload();
                    end
                    default: ;
                endcase
            end
            if (i_blk.valid && i_blk.ready)
                absorb(i_blk.word_low, i_blk.word_high, i_blk.valid_bytes, i_blk.last);
            if (i_hash.valid && i_hash.ready) begin
                got = {i_hash.hash_low, i_hash.hash_high, i_hash.length_overflow};
                if (digest_q.size() == 0) begin
                    fails++;
                    if (shown < 10)
                        $display("%0t: hash beat with none expected: lo=%h hi=%h ovf=%b",
                                 $time, got.lo, got.hi, got.ovf);
                    shown++;
                end else begin
                    want = digest_q.pop_front();
                    if (got.lo !== want.lo || got.hi !== want.hi || got.ovf !== want.ovf) begin
                        fails++;
                        if (shown < 10)
                            $display("%0t: digest mismatch exp lo=%h hi=%h ovf=%b",
                                     $time, want.lo, want.hi, want.ovf,
                                     " got lo=%h hi=%h ovf=%b",
                                     got.lo, got.hi, got.ovf);
                        shown++;
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_open_digests <= digest_q.size();
    end

endmodule

@@ tb/sv/tb_murmur3_128_block_hasher.sv @@
`timescale 1ns / 100ps

module tb_murmur3_128_block_hasher;

    localparam int N_ITEMS       = 1550;
    // give the datapath room to finish a non-final block or a digest before touching registers
    localparam int SETTLE_CYCLES = 30;
    // ~1600 beats plus drains, taken several times over
    localparam int CYCLE_LIMIT   = 400000;

    // register indexes past the two real ones; writes there must do nothing
    localparam logic [mm3h_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [mm3h_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [mm3h_pkg::WORD_W-1:0]    ONES        = '1;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [mm3h_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [mm3h_pkg::WORD_W-1:0]    cfg_data;

    int   beats_sent   = 0;
    int   cycle_count  = 0;
    int   ready_hold   = 0;
    logic calm         = 1'b0;   // no idling on either side once set
    int   fail_count;
    int   open_digests;

    mm3h_in_if  blk_ch ();
    mm3h_out_if hash_ch ();

    murmur3_128_block_hasher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blk      (blk_ch),
        .o_hash     (hash_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mm3h_digest_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_blk          (blk_ch),
        .i_hash         (hash_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_open_digests (open_digests)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hash-side backpressure: random ready stalls, none in the calm tail
    always @(posedge i_clk) begin
        if (calm) begin
            hash_ch.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            hash_ch.ready <= 1'b0;
            ready_hold--;
        end else if ($urandom_range(0, 5) == 0) begin
            hash_ch.ready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
        end else begin
            hash_ch.ready <= 1'b1;
        end
    end

    function automatic logic [mm3h_pkg::WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one block beat and hold it until accepted. Valid is only
    // dropped for an idle burst or a drain, so back-to-back beats keep it high.
    task automatic push_beat(input logic [mm3h_pkg::WORD_W-1:0] wl,
                             input logic [mm3h_pkg::WORD_W-1:0] wh,
                             input logic [mm3h_pkg::COUNT_W-1:0] nb, input logic fin);
        if (!calm && $urandom_range(0, 4) == 0) begin
            blk_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        blk_ch.valid       <= 1'b1;
        blk_ch.word_low    <= wl;
        blk_ch.word_high   <= wh;
        blk_ch.valid_bytes <= nb;
        blk_ch.last        <= fin;
        do @(posedge i_clk); while (blk_ch.ready !== 1'b1);
        beats_sent++;
        if (beats_sent >= N_ITEMS * 85 / 100) calm <= 1'b1;
    endtask

    // Wait until every predicted digest has come back, then let the
    // datapath finish any non-final block still in flight.
    task automatic drain();
        blk_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (open_digests != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable after a group
    task automatic reg_write(input logic [mm3h_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mm3h_pkg::WORD_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    initial begin
        logic [mm3h_pkg::WORD_W-1:0] seed_pick;
        int                          msgs;
        int                          blocks;

        blk_ch.valid       <= 1'b0;
        blk_ch.word_low    <= '0;
        blk_ch.word_high   <= '0;
        blk_ch.valid_bytes <= '0;
        blk_ch.last        <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= mm3h_pkg::CFG_SEED;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset settings, seed 0, standard mode ----
        // empty message; payload bytes must be ignored
        push_beat(ONES, ONES, 5'd0, 1'b1);
        // tail lengths around the 8-byte word boundary
        push_beat(ONES, ONES, 5'd1, 1'b1);
        push_beat(rand64(), rand64(), 5'd8, 1'b1);
        push_beat(rand64(), rand64(), 5'd9, 1'b1);
        push_beat(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd15, 1'b1);
        // full final block
        push_beat(ONES, ONES, 5'd16, 1'b1);
        // counts above sixteen saturate on a final beat
        push_beat(rand64(), rand64(), 5'd31, 1'b1);
        // three-block message: a short non-final count still counts as 16
        push_beat('0, '0, 5'd16, 1'b0);
        push_beat(rand64(), rand64(), 5'd3, 1'b0);
        push_beat(rand64(), rand64(), 5'd17, 1'b1);

        // all-ones seed: only the low half counts in standard mode
        drain();
        reg_write(mm3h_pkg::CFG_SEED, ONES);
        cfg_we <= 1'b0;
        push_beat(rand64(), rand64(), 5'd7, 1'b1);

        // 64-bit variant: full seed, sign-extended tail bytes
        drain();
        reg_write(mm3h_pkg::CFG_MODE, 64'd1);
        cfg_we <= 1'b0;
        push_beat({8{8'h80}}, '0, 5'd5, 1'b1);
        push_beat(ONES, ONES, 5'd12, 1'b1);
        push_beat(rand64(), rand64(), 5'd16, 1'b0);
        push_beat(rand64(), rand64(), 5'd16, 1'b1);
        push_beat(ONES, ONES, 5'd0, 1'b1);

        // writes past the register map change nothing
        drain();
        reg_write(CFG_SPARE_2, ONES);
        reg_write(CFG_SPARE_3, '0);
        cfg_we <= 1'b0;
        push_beat(rand64(), rand64(), 5'd10, 1'b1);

        // a register write abandons the message in progress
        push_beat(rand64(), rand64(), 5'd16, 1'b0);
        drain();
        reg_write(mm3h_pkg::CFG_SEED, '0);
        cfg_we <= 1'b0;
        push_beat(rand64(), rand64(), 5'd4, 1'b1);

        // ---- random phases: new settings, then a batch of messages ----
        while (beats_sent < N_ITEMS) begin
            drain();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0:       seed_pick = '0;
                    1:       seed_pick = ONES;
                    2:       seed_pick = {32'h0, $urandom};
                    default: seed_pick = rand64();
                endcase
                reg_write(mm3h_pkg::CFG_SEED, seed_pick);
            end
            // random data; only bit 0 selects the mode
            if ($urandom_range(0, 2) == 0) reg_write(mm3h_pkg::CFG_MODE, rand64());
            if ($urandom_range(0, 7) == 0)
                reg_write($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, rand64());
            cfg_we <= 1'b0;

            msgs = $urandom_range(1, 10);
            repeat (msgs) begin
                if ($urandom_range(0, 19) == 0) begin
                    // stray non-final beat; it joins the next message or is
                    // abandoned by the next register write
                    push_beat(rand64(), rand64(),
                              mm3h_pkg::COUNT_W'($urandom_range(0, 31)), 1'b0);
                end else begin
                    blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                         : $urandom_range(0, 3);
                    repeat (blocks)
                        push_beat(rand64(), rand64(),
                                  ($urandom_range(0, 7) == 0) ?
                                      mm3h_pkg::COUNT_W'($urandom_range(0, 31)) :
                                      mm3h_pkg::BLOCK_BYTES,
                                  1'b0);
                    push_beat(rand64(), rand64(),
                              ($urandom_range(0, 7) == 0) ?
                                  mm3h_pkg::COUNT_W'($urandom_range(17, 31)) :
                                  mm3h_pkg::COUNT_W'($urandom_range(0, 16)),
                              1'b1);
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mm3h_pkg.sv
rtl/mm3h_in_if.sv
rtl/mm3h_out_if.sv
rtl/mm3h_datapath.sv
rtl/mm3h_ctrl.sv
rtl/murmur3_128_block_hasher.sv
tb/sv/mm3h_digest_checker.sv
tb/sv/tb_murmur3_128_block_hasher.sv
